// ===== rtl/sbm_pkg.sv =====
// Package: constants and register codes shared by the SAD block-matching disparity block.
package sbm_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int WINDOW_RADIUS  = 7;
  localparam int MAX_DISP_LIMIT = 64;
  localparam int STORE_ROWS     = 16;
  localparam int HEIGHT_CAP     = 1024;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 10;
  localparam int DIM_W  = 11;
  localparam int DISP_W = 7;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_DISPARITY = 2'd2;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 11'd480;
  localparam logic [DISP_W-1:0] RST_MAX_DISPARITY = 7'd20;

endpackage

// ===== rtl/sbm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sbm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sbm_div #(
  parameter int NW = 21,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   dvs;
  logic [DW:0]     trial;
  logic            ge;

  assign trial = {rem, quot[NW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == CNTW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dvs  <= den;
    end else if (run) begin
      quot <= {quot[NW-2:0], ge};
      rem  <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
    end
  end

endmodule

// ===== rtl/sad_block_match_disparity.sv =====
// Top level: streaming 15x15 SAD block-matching stereo disparity over line-store RAMs.
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  kind, left_pixel, right_pixel
//  out      out  out_valid/out_stall disparity_pixel, out_column, out_row, last_of_frame
//  cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction at a time. A pixel pair's store address comes from dividing its count by
// the width, then taking that row modulo the store rows, then the RAM write; a drain tick
// skips these steps. A result needs the position divide, SAD over d+1 disparities with one
// window term per cycle through the RAM read port, and the scaling divide; a margin result
// skips the SAD and scaling divide. Reset is synchronous; RAM contents are not cleared.
// A result waits in the output register; the next transaction is taken meanwhile.
module sad_block_match_disparity #(
  parameter int MAX_WIDTH      = sbm_pkg::MAX_WIDTH,
  parameter int WINDOW_RADIUS  = sbm_pkg::WINDOW_RADIUS,
  parameter int MAX_DISP_LIMIT = sbm_pkg::MAX_DISP_LIMIT,
  parameter int STORE_ROWS     = sbm_pkg::STORE_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [sbm_pkg::PIX_W-1:0]   left_pixel,
  input  logic [sbm_pkg::PIX_W-1:0]   right_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbm_pkg::PIX_W-1:0]   disparity_pixel,
  output logic [sbm_pkg::POS_W-1:0]   out_column,
  output logic [sbm_pkg::POS_W-1:0]   out_row,
  output logic                        last_of_frame,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sbm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sbm_pkg::DIM_W-1:0]   cfg_data
);

  localparam int HEIGHT_CAP = sbm_pkg::HEIGHT_CAP;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(HEIGHT_CAP + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int DW    = $clog2(MAX_DISP_LIMIT + 1);
  localparam int SRW   = $clog2(STORE_ROWS);
  localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_WIDTH * HEIGHT_CAP + 1);
  localparam int QN_W  = $clog2(MAX_DISP_LIMIT * 255 + 1);
  localparam int NW    = (CNT_W > QN_W) ? CNT_W : QN_W;
  localparam int SDW   = $clog2(STORE_ROWS + 1);
  localparam int DDW0  = (WW > DW) ? WW : DW;
  localparam int DDW   = (DDW0 > SDW) ? DDW0 : SDW;
  localparam int CW    = ((WW > HW) ? WW : HW) + 2;
  localparam int KW    = $clog2(WINDOW_RADIUS + 1) + 1;
  localparam int SIDE  = 2 * WINDOW_RADIUS + 1;
  localparam int COST_W = $clog2(SIDE * SIDE * 255 + 1);
  localparam int TOP_ADD = STORE_ROWS * ((WINDOW_RADIUS + STORE_ROWS - 1) / STORE_ROWS)
                           - WINDOW_RADIUS;
  localparam int PW = sbm_pkg::PIX_W;
  // row modulo store rows by reciprocal multiply
  localparam int RN = 20;
  localparam int RM = (2 ** RN + STORE_ROWS - 1) / STORE_ROWS;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WPOS  = 4'd1;
  localparam logic [3:0] ST_WROW  = 4'd2;
  localparam logic [3:0] ST_WRITE = 4'd3;
  localparam logic [3:0] ST_CHECK = 4'd4;
  localparam logic [3:0] ST_EPOS  = 4'd5;
  localparam logic [3:0] ST_EROW  = 4'd6;
  localparam logic [3:0] ST_SCAN  = 4'd7;
  localparam logic [3:0] ST_FLUSH = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_QDIV  = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0] state;

  logic [sbm_pkg::DIM_W-1:0]  image_width;
  logic [sbm_pkg::DIM_W-1:0]  image_height;
  logic [sbm_pkg::DISP_W-1:0] max_disparity;

  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [DW-1:0]    d;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] lag;

  logic [CNT_W-1:0] received;
  logic [CNT_W-1:0] emitted;
  logic             in_accept;
  logic             clr;
  logic [CNT_W-1:0] recv_e;

  logic [PW-1:0]  lpix;
  logic [PW-1:0]  rpix;
  logic [XW-1:0]  wcol;
  logic [SRW-1:0] wsrow;

  logic signed [CW-1:0] ex;
  logic signed [CW-1:0] ey;
  logic signed [CW-1:0] ws;
  logic signed [CW-1:0] hs;
  logic signed [CW-1:0] ds;
  logic signed [CW-1:0] row;
  logic signed [CW-1:0] lc;
  logic signed [CW-1:0] rc;
  logic                 term_ok;
  logic                 margin;

  logic [SRW-1:0]       top_srow;
  logic [SRW-1:0]       srow_j;
  logic [DW-1:0]        cd;
  logic [DW-1:0]        bd;
  logic [DW-1:0]        bd_next;
  logic signed [KW-1:0] kk;
  logic signed [KW-1:0] jj;
  logic [COST_W-1:0]    cost;
  logic [COST_W-1:0]    best;
  logic                 have;
  logic                 rd_ok;
  logic [PW-1:0]        result;

  logic [HW-1:0]        sr_num;
  logic [HW+RN-1:0]     sr_prod;
  logic [HW-1:0]        sr_quo;
  logic [SRW-1:0]       sr_mod;

  logic          div_go;
  logic          div_go_next;
  logic [NW-1:0] div_num;
  logic [DDW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_q;
  logic [DDW-1:0] div_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] laddr;
  logic [AW-1:0] raddr;
  logic [PW-1:0] ldata;
  logic [PW-1:0] rdata;
  logic [PW-1:0] adiff;
  logic          emit_go;
  logic          out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != ST_IDLE;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= sbm_pkg::RST_IMAGE_WIDTH;
      image_height  <= sbm_pkg::RST_IMAGE_HEIGHT;
      max_disparity <= sbm_pkg::RST_MAX_DISPARITY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbm_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        sbm_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        sbm_pkg::REG_MAX_DISPARITY: max_disparity <= cfg_data[sbm_pkg::DISP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) w = WW'(1);
    else if (image_width > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(image_width);
    if (image_height == '0) h = HW'(1);
    else if (image_height > HEIGHT_CAP) h = HW'(HEIGHT_CAP);
    else h = HW'(image_height);
    if (max_disparity == '0) d = DW'(1);
    else if (max_disparity > MAX_DISP_LIMIT) d = DW'(MAX_DISP_LIMIT);
    else d = DW'(max_disparity);
  end

  assign total  = CNT_W'(w) * CNT_W'(h);
  assign lag    = CNT_W'(WINDOW_RADIUS) * CNT_W'(w) + CNT_W'(WINDOW_RADIUS);
  assign clr    = emitted >= total;
  assign recv_e = clr ? '0 : received;
  assign emit_go = (received >= total) ||
                   ((received > emitted) && ((received - emitted) > lag));

  assign ws = $signed(CW'(w));
  assign hs = $signed(CW'(h));
  assign ds = $signed(CW'(d));
  assign row = ey + CW'(jj);
  assign lc  = ex + CW'(kk);
  assign rc  = ex - $signed(CW'(cd)) + CW'(kk);
  assign term_ok = (row >= 0) && (row < hs) && (lc >= 0) && (lc < ws) &&
                   (rc >= 0) && (rc < ws);
  assign margin = (ex < ds) || (ex >= ws - ds) || (ey < ds) || (ey >= hs - ds);

  assign sr_prod = (HW+RN)'(sr_num) * (HW+RN)'(RM);
  assign sr_quo  = sr_prod[HW+RN-1:RN];
  assign sr_mod  = SRW'(sr_num - sr_quo * HW'(STORE_ROWS));

  assign div_go_next = (state == ST_IDLE && in_accept && !kind && recv_e < total) ||
                       (state == ST_CHECK && emit_go) ||
                       (state == ST_CMP && cd == '0);

  assign we    = state == ST_WRITE;
  assign waddr = AW'(wsrow * MAX_WIDTH) + AW'(wcol);
  assign laddr = AW'(srow_j * MAX_WIDTH) + AW'(lc[XW-1:0]);
  assign raddr = AW'(srow_j * MAX_WIDTH) + AW'(rc[XW-1:0]);
  assign adiff = (ldata > rdata) ? ldata - rdata : rdata - ldata;
  assign bd_next = (!have || cost < best) ? cd : bd;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  sbm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_left_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(lpix), .raddr(laddr), .rdata(ldata)
  );

  sbm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_right_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(rpix), .raddr(raddr), .rdata(rdata)
  );

  sbm_div #(.NW(NW), .DW(DDW)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      received  <= '0;
      emitted   <= '0;
      div_go    <= 1'b0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_go <= div_go_next;
      rd_ok  <= (state == ST_SCAN) && term_ok;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (clr) begin
              received <= '0;
              emitted  <= '0;
            end
            lpix <= left_pixel;
            rpix <= right_pixel;
            if (!kind && recv_e < total) begin
              div_num <= NW'(recv_e);
              div_den <= DDW'(w);
              state   <= ST_WPOS;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_WPOS: begin
          if (div_done) begin
            wcol   <= div_r[XW-1:0];
            sr_num <= div_q[HW-1:0];
            state  <= ST_WROW;
          end
        end
        ST_WROW: begin
          wsrow <= sr_mod;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          received <= received + 1'b1;
          state    <= ST_CHECK;
        end
        ST_CHECK: begin
          if (emit_go) begin
            div_num <= NW'(emitted);
            div_den <= DDW'(w);
            state   <= ST_EPOS;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EPOS: begin
          if (div_done) begin
            ex     <= $signed(CW'(div_r));
            ey     <= $signed(CW'(div_q));
            sr_num <= div_q[HW-1:0] + HW'(TOP_ADD);
            state  <= ST_EROW;
          end
        end
        ST_EROW: begin
          top_srow <= sr_mod;
          srow_j   <= sr_mod;
          cd       <= d;
          kk       <= -KW'(WINDOW_RADIUS);
          jj       <= -KW'(WINDOW_RADIUS);
          have     <= 1'b0;
          result   <= '0;
          state    <= margin ? ST_OUT : ST_SCAN;
        end
        ST_SCAN: begin
          if (jj == KW'(WINDOW_RADIUS)) begin
            jj     <= -KW'(WINDOW_RADIUS);
            srow_j <= top_srow;
            if (kk == KW'(WINDOW_RADIUS)) begin
              kk    <= -KW'(WINDOW_RADIUS);
              state <= ST_FLUSH;
            end else begin
              kk <= kk + 1'b1;
            end
          end else begin
            jj     <= jj + 1'b1;
            srow_j <= (srow_j == SRW'(STORE_ROWS - 1)) ? '0 : srow_j + 1'b1;
          end
        end
        ST_FLUSH: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (!have || cost < best) begin
            best <= cost;
          end
          bd   <= bd_next;
          have <= 1'b1;
          if (cd == '0) begin
            div_num <= NW'(bd_next) * NW'(255);
            div_den <= DDW'(d);
            state   <= ST_QDIV;
          end else begin
            cd    <= cd - 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_QDIV: begin
          if (div_done) begin
            result <= div_q[PW-1:0];
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            disparity_pixel <= result;
            out_column      <= sbm_pkg::POS_W'(ex);
            out_row         <= sbm_pkg::POS_W'(ey);
            last_of_frame   <= (emitted + 1'b1) >= total;
            if ((emitted + 1'b1) >= total) begin
              emitted  <= '0;
              received <= '0;
            end else begin
              emitted <= emitted + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CMP || state == ST_EROW) begin
      cost <= '0;
    end else if (rd_ok) begin
      cost <= cost + COST_W'(adiff);
    end
  end

endmodule
